>>> rtl/ggpc_pkg.sv
// shared types, constants and helper functions of the go-to-goal controller
package ggpc_pkg;

  // widths of the cordic datapath
  localparam int unsigned DW  = 25;  // scaled position difference, Q.8
  localparam int unsigned XW  = 28;  // cordic x/y with headroom for gain growth
  localparam int unsigned ZW  = 21;  // angle, Q.16 radians
  localparam int unsigned MAW = 28;  // multiplier operand a
  localparam int unsigned MBW = 17;  // multiplier operand b
  localparam int unsigned MPW = MAW + MBW;

  // angle constants in Q.16 radians
  localparam logic signed [ZW-1:0] ANG_HALF_PI = 21'sd102944;
  localparam logic signed [ZW-1:0] ANG_PI      = 21'sd205887;

  // inverse cordic gain, Q.16
  localparam logic [15:0] INV_GAIN = 16'd39797;

  // configuration register indexes
  localparam logic [2:0] CFG_LINEAR_GAIN  = 3'd0;
  localparam logic [2:0] CFG_ANGULAR_GAIN = 3'd1;
  localparam logic [2:0] CFG_STOP_TOL     = 3'd2;
  localparam logic [2:0] CFG_WALL_LEFT    = 3'd3;
  localparam logic [2:0] CFG_WALL_RIGHT   = 3'd4;
  localparam logic [2:0] CFG_WALL_BOTTOM  = 3'd5;
  localparam logic [2:0] CFG_WALL_TOP     = 3'd6;

  // input opcodes
  localparam logic OP_GOAL = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // control of one cordic pass
  typedef struct packed {
    logic start;
    logic vector;  // 1 vectoring (atan2), 0 rotation
  } cordic_ctrl_t;

  // arctangent of 2^-i in Q.16 radians
  function automatic logic signed [ZW-1:0] atan_at(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:    v = 21'sd51472;
      5'd1:    v = 21'sd30386;
      5'd2:    v = 21'sd16055;
      5'd3:    v = 21'sd8150;
      5'd4:    v = 21'sd4091;
      5'd5:    v = 21'sd2047;
      5'd6:    v = 21'sd1024;
      5'd7:    v = 21'sd512;
      5'd8:    v = 21'sd256;
      5'd9:    v = 21'sd128;
      5'd10:   v = 21'sd64;
      5'd11:   v = 21'sd32;
      5'd12:   v = 21'sd16;
      5'd13:   v = 21'sd8;
      5'd14:   v = 21'sd4;
      5'd15:   v = 21'sd2;
      5'd16:   v = 21'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // saturate to a signed 16-bit value
  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    logic signed [15:0] r;
    if (v > 32'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -32'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/ggpc_cordic.sv
// iterative cordic unit, one micro-rotation per cycle, vectoring or rotation
module ggpc_cordic #(
  parameter int unsigned N = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ggpc_pkg::cordic_ctrl_t        ctrl_i,
  input  logic signed [ggpc_pkg::DW-1:0] x_i,
  input  logic signed [ggpc_pkg::DW-1:0] y_i,
  input  logic signed [ggpc_pkg::ZW-1:0] z_i,
  output logic                          done_o,
  output logic signed [ggpc_pkg::XW-1:0] x_o,
  output logic signed [ggpc_pkg::ZW-1:0] z_o
);
  import ggpc_pkg::*;

  localparam int unsigned IW = $clog2(N);
  localparam logic [IW-1:0] LAST = IW'(N - 1);

  logic              busy_q, done_q, vec_q, zero_q;
  logic [IW-1:0]     it_q;
  logic signed [XW-1:0] x_q, y_q, x_d, y_d, xs, ys;
  logic signed [ZW-1:0] z_q, z_d;
  logic signed [XW-1:0] xe, ye, px, py;
  logic signed [ZW-1:0] pz, ang;
  logic              pos;

  // quadrant pre-rotation of the start vector
  always_comb begin
    xe = {{(XW-DW){x_i[DW-1]}}, x_i};
    ye = {{(XW-DW){y_i[DW-1]}}, y_i};
    px = xe;
    py = ye;
    pz = '0;
    if (ctrl_i.vector) begin
      if (xe < 0) begin
        if (ye >= 0) begin
          px = ye;
          py = -xe;
          pz = ANG_HALF_PI;
        end else begin
          px = -ye;
          py = xe;
          pz = -ANG_HALF_PI;
        end
      end
    end else begin
      pz = z_i;
      if (z_i > ANG_HALF_PI) begin
        pz = z_i - ANG_PI;
        px = -xe;
        py = -ye;
      end else if (z_i < -ANG_HALF_PI) begin
        pz = z_i + ANG_PI;
        px = -xe;
        py = -ye;
      end
    end
  end

  // one micro-rotation
  always_comb begin
    xs  = x_q >>> it_q;
    ys  = y_q >>> it_q;
    ang = atan_at(5'(it_q));
    pos = vec_q ? y_q[XW-1] : ~z_q[ZW-1];
    if (pos) begin
      x_d = x_q - ys;
      y_d = y_q + xs;
      z_d = z_q - ang;
    end else begin
      x_d = x_q + ys;
      y_d = y_q - xs;
      z_d = z_q + ang;
    end
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        it_q   <= '0;
      end else if (busy_q) begin
        if (it_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          it_q <= it_q + 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      x_q    <= px;
      y_q    <= py;
      z_q    <= pz;
      vec_q  <= ctrl_i.vector;
      zero_q <= ctrl_i.vector && (x_i == '0) && (y_i == '0);
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign done_o = done_q;
  assign x_o    = x_q;
  // zero vector has angle zero
  assign z_o    = zero_q ? '0 : z_q;

endmodule

>>> rtl/ggpc_mul.sv
// shared signed multiplier with a registered product
module ggpc_mul (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic signed [ggpc_pkg::MAW-1:0] a_i,
  input  logic signed [ggpc_pkg::MBW-1:0] b_i,
  output logic signed [ggpc_pkg::MPW-1:0] p_o
);
  import ggpc_pkg::*;

  logic signed [MPW-1:0] p_q;

  // product register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= MPW'(a_i) * MPW'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

>>> rtl/go_to_goal_p_controller_core.sv
// top level of the go-to-goal proportional controller
// A goal item stores the target and gives no result. A tick item runs a
// vectoring cordic pass for the bearing, a rotation cordic pass for the projected distance and
// three products on one shared multiplier; a tick that is stopped or whose goal lies outside
// the walls skips both and goes straight to the final state. One item is in work at a time;
// the result sits in an output register, so a new item is taken while it waits.
module go_to_goal_p_controller_core #(
  parameter int unsigned CORDIC_ITERATIONS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input items
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               opcode_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] heading_i,
  // result items
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               cmd_valid_o,
  output logic signed [15:0] linear_speed_o,
  output logic signed [15:0] angular_speed_o,
  output logic               out_of_range_o,
  output logic               idle_waiting_o,
  output logic               goal_reached_o,
  // configuration
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i
);
  import ggpc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_VEC_GO, S_VEC_RUN, S_ROT_GO, S_ROT_RUN,
    S_MUL_ERR, S_MUL_LIN, S_MUL_ANG, S_MUL_END, S_FIN
  } state_e;

  state_e state_q;

  // configuration registers
  logic [15:0]        lin_gain_q, ang_gain_q;
  logic [14:0]        stop_tol_q;
  logic signed [15:0] wall_l_q, wall_r_q, wall_b_q, wall_t_q;

  // controller state
  logic signed [15:0] goal_x_q, goal_y_q, lle_q;
  logic               stopped_q;

  // per-item working registers
  logic signed [DW-1:0] dx_q, dy_q;
  logic signed [15:0]   hd_q;
  logic signed [ZW-1:0] zvec_q;
  logic signed [17:0]   lerr_q;
  logic signed [15:0]   lin_q, ang_q;
  logic                 cmd_q, oor_q, idle_q;

  // output register
  logic               out_valid_q, cmd_out_q, oor_out_q, idle_out_q, reached_out_q;
  logic signed [15:0] lin_out_q, ang_out_q;

  logic                 in_acc, in_walls, out_free, reached;
  logic signed [16:0]   dx17, dy17;
  logic signed [ZW-1:0] hz, aerr;
  logic signed [17:0]   lerr_d;
  logic [15:0]          lle_mag;

  cordic_ctrl_t         cctrl;
  logic                 c_done;
  logic signed [XW-1:0] c_x;
  logic signed [ZW-1:0] c_z, c_zin;
  logic                 m_en;
  logic signed [MAW-1:0] m_a;
  logic signed [MBW-1:0] m_b;
  logic signed [MPW-1:0] m_p;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // goal window check and position differences
  assign in_walls = (goal_x_q >= wall_l_q) && (goal_x_q <= wall_r_q) &&
                    (goal_y_q >= wall_b_q) && (goal_y_q <= wall_t_q);
  assign dx17   = 17'(goal_x_q) - 17'(pos_x_i);
  assign dy17   = 17'(goal_y_q) - 17'(pos_y_i);

  // heading in Q.16 and angular error
  assign hz   = {{(ZW-19){hd_q[15]}}, hd_q, 3'b000};
  assign aerr = zvec_q - hz;

  // linear error out of the projection product
  assign lerr_d  = m_p[41:24];
  assign lle_mag = lle_q[15] ? 16'(-17'(lle_q)) : 16'(lle_q);
  assign reached = {1'b0, lle_mag} < {2'b00, stop_tol_q};

  // cordic control
  always_comb begin
    cctrl.start  = (state_q == S_VEC_GO) || (state_q == S_ROT_GO);
    cctrl.vector = (state_q == S_VEC_GO);
    c_zin        = -hz;
  end

  // multiplier operand selection
  always_comb begin
    m_en = 1'b0;
    m_a  = '0;
    m_b  = '0;
    case (state_q)
      S_MUL_ERR: begin
        m_en = 1'b1;
        m_a  = c_x;
        m_b  = {1'b0, INV_GAIN};
      end
      S_MUL_LIN: begin
        m_en = 1'b1;
        m_a  = {{(MAW-18){lerr_d[17]}}, lerr_d};
        m_b  = {1'b0, lin_gain_q};
      end
      S_MUL_ANG: begin
        m_en = 1'b1;
        m_a  = {{(MAW-ZW){aerr[ZW-1]}}, aerr};
        m_b  = {1'b0, ang_gain_q};
      end
      default: begin
        m_en = 1'b0;
      end
    endcase
  end

  ggpc_cordic #(
    .N(CORDIC_ITERATIONS)
  ) u_cordic (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(cctrl),
    .x_i   (dx_q),
    .y_i   (dy_q),
    .z_i   (c_zin),
    .done_o(c_done),
    .x_o   (c_x),
    .z_o   (c_z)
  );

  ggpc_mul u_mul (
    .clk_i(clk_i),
    .en_i (m_en),
    .a_i  (m_a),
    .b_i  (m_b),
    .p_o  (m_p)
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_gain_q <= 16'd2048;
      ang_gain_q <= 16'd16384;
      stop_tol_q <= 15'd20;
      wall_l_q   <= 16'sd0;
      wall_r_q   <= 16'sd22528;
      wall_b_q   <= 16'sd0;
      wall_t_q   <= 16'sd22528;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LINEAR_GAIN:  lin_gain_q <= cfg_data_i;
        CFG_ANGULAR_GAIN: ang_gain_q <= cfg_data_i;
        CFG_STOP_TOL:     stop_tol_q <= cfg_data_i[14:0];
        CFG_WALL_LEFT:    wall_l_q   <= cfg_data_i;
        CFG_WALL_RIGHT:   wall_r_q   <= cfg_data_i;
        CFG_WALL_BOTTOM:  wall_b_q   <= cfg_data_i;
        CFG_WALL_TOP:     wall_t_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // sequencer, controller state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      goal_x_q      <= '0;
      goal_y_q      <= '0;
      stopped_q     <= 1'b1;
      lle_q         <= '0;
      out_valid_q   <= 1'b0;
      cmd_q         <= 1'b0;
      oor_q         <= 1'b0;
      idle_q        <= 1'b0;
      cmd_out_q     <= 1'b0;
      oor_out_q     <= 1'b0;
      idle_out_q    <= 1'b0;
      reached_out_q <= 1'b0;
      lin_out_q     <= '0;
      ang_out_q     <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != S_FIN)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (opcode_i == OP_GOAL) begin
              goal_x_q  <= pos_x_i;
              goal_y_q  <= pos_y_i;
              stopped_q <= 1'b0;
            end else begin
              idle_q  <= stopped_q;
              cmd_q   <= !stopped_q && in_walls;
              oor_q   <= !stopped_q && !in_walls;
              state_q <= (!stopped_q && in_walls) ? S_VEC_GO : S_FIN;
            end
          end
        end
        S_VEC_GO:  state_q <= S_VEC_RUN;
        S_VEC_RUN: begin
          if (c_done) begin
            state_q <= S_ROT_GO;
          end
        end
        S_ROT_GO:  state_q <= S_ROT_RUN;
        S_ROT_RUN: begin
          if (c_done) begin
            state_q <= S_MUL_ERR;
          end
        end
        S_MUL_ERR: state_q <= S_MUL_LIN;
        S_MUL_LIN: begin
          lle_q   <= sat16({{14{lerr_d[17]}}, lerr_d});
          state_q <= S_MUL_ANG;
        end
        S_MUL_ANG: state_q <= S_MUL_END;
        S_MUL_END: state_q <= S_FIN;
        S_FIN: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            cmd_out_q     <= cmd_q;
            oor_out_q     <= oor_q;
            idle_out_q    <= idle_q;
            reached_out_q <= reached;
            lin_out_q     <= cmd_q ? lin_q : '0;
            ang_out_q     <= cmd_q ? ang_q : '0;
            if (reached) begin
              stopped_q <= 1'b1;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // item datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc && (opcode_i == OP_TICK)) begin
      dx_q <= {dx17, 8'h00};
      dy_q <= {dy17, 8'h00};
      hd_q <= heading_i;
    end
    if ((state_q == S_VEC_RUN) && c_done) begin
      zvec_q <= c_z;
    end
    if (state_q == S_MUL_LIN) begin
      lerr_q <= lerr_d;
    end
    // linear speed only for a positive error
    if (state_q == S_MUL_ANG) begin
      lin_q <= (!lerr_q[17] && (lerr_q != '0)) ?
               sat16({{2{m_p[MPW-1]}}, m_p[MPW-1:15]}) : '0;
    end
    if (state_q == S_MUL_END) begin
      ang_q <= sat16({{7{m_p[MPW-1]}}, m_p[MPW-1:20]});
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cmd_valid_o     = cmd_out_q;
  assign linear_speed_o  = lin_out_q;
  assign angular_speed_o = ang_out_q;
  assign out_of_range_o  = oor_out_q;
  assign idle_waiting_o  = idle_out_q;
  assign goal_reached_o  = reached_out_q;

endmodule

>>> rtl/ggpc_checker.sv
// port-level checks of the go-to-goal controller, bound to the top level
module ggpc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               opcode_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               cmd_valid_o,
  input logic signed [15:0] linear_speed_o,
  input logic signed [15:0] angular_speed_o,
  input logic               out_of_range_o,
  input logic               idle_waiting_o
);
  import ggpc_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(linear_speed_o)
      && $stable(angular_speed_o))
    else $error("stalled result changed");

  // exactly one of command, out of range, idle
  a_one_case: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot({cmd_valid_o, out_of_range_o, idle_waiting_o}))
    else $error("result case flags not one-hot");

  // no command means zero speeds
  a_zero_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !cmd_valid_o |-> (linear_speed_o == '0) && (angular_speed_o == '0))
    else $error("speed without command");

  // linear speed never negative
  a_lin_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !linear_speed_o[15])
    else $error("negative linear speed");

  // a tick item keeps the block busy for the next cycle
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (opcode_i == OP_TICK) |=> in_stall_o)
    else $error("tick item did not occupy the block");

endmodule

bind go_to_goal_p_controller_core ggpc_checker u_ggpc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .opcode_i       (opcode_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .cmd_valid_o    (cmd_valid_o),
  .linear_speed_o (linear_speed_o),
  .angular_speed_o(angular_speed_o),
  .out_of_range_o (out_of_range_o),
  .idle_waiting_o (idle_waiting_o)
);

>>> verif/ggpc_command_checker.sv
// channel monitor, command predictor and result comparison for the go-to-goal controller
module ggpc_command_checker #(
  parameter int unsigned ITERS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               opcode_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] heading_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               cmd_valid_i,
  input  logic signed [15:0] linear_speed_i,
  input  logic signed [15:0] angular_speed_i,
  input  logic               out_of_range_i,
  input  logic               idle_waiting_i,
  input  logic               goal_reached_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  output int                 mismatches_o,
  output int                 pending_o
);
  import ggpc_pkg::*;

  localparam int unsigned STEPS = (ITERS > 24) ? 24 : ITERS;
  localparam longint HALF_PI_Q16 = 102944;
  localparam longint PI_Q16 = 205887;
  localparam longint INV_GAIN_Q16 = 39797;
  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    logic               cmd_valid;
    logic signed [15:0] linear_speed;
    logic signed [15:0] angular_speed;
    logic               out_of_range;
    logic               idle_waiting;
    logic               goal_reached;
  } motion_cmd_t;

  // predictor copy of the configuration
  logic        [15:0] lin_gain;
  logic        [15:0] ang_gain;
  logic        [14:0] stop_tol;
  logic signed [15:0] wall_l, wall_r, wall_b, wall_t;

  // predictor copy of the controller state
  logic signed [15:0] goal_x, goal_y;
  logic               stopped;
  logic signed [15:0] kept_error;

  motion_cmd_t expected_cmds[$];
  motion_cmd_t want_cmd;

  // arctangent of 2^-i, Q.16 radians
  function automatic longint atan_step(input int i);
    case (i)
      0:       return 51472;
      1:       return 30386;
      2:       return 16055;
      3:       return 8150;
      4:       return 4091;
      5:       return 2047;
      6:       return 1024;
      7:       return 512;
      8:       return 256;
      9:       return 128;
      10:      return 64;
      11:      return 32;
      12:      return 16;
      13:      return 8;
      14:      return 4;
      15:      return 2;
      16:      return 1;
      default: return 0;
    endcase
  endfunction

  function automatic logic signed [15:0] clamp16(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // vectoring pass: bearing of (x, y), zero for the zero vector
  function automatic longint bearing_q16(input longint x0, input longint y0);
    longint x, y, z, t, xs, ys;
    int i;
    x = x0;
    y = y0;
    z = 0;
    if (x == 0 && y == 0) return 0;
    // pre-rotate the left half plane by a quarter turn
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = HALF_PI_Q16;
      end else begin
        x = -y;
        y = t;
        z = -HALF_PI_Q16;
      end
    end
    for (i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_step(i);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - atan_step(i);
      end
    end
    return z;
  endfunction

  // rotation pass: x of (x, y) turned by z, still carrying the cordic gain
  function automatic longint project_x(input longint x0, input longint y0, input longint z0);
    longint x, y, z, xs, ys;
    int i;
    x = x0;
    y = y0;
    z = z0;
    // fold the angle into +-pi/2 by a half turn
    if (z > HALF_PI_Q16) begin
      z = z - PI_Q16;
      x = -x;
      y = -y;
    end else if (z < -HALF_PI_Q16) begin
      z = z + PI_Q16;
      x = -x;
      y = -y;
    end
    for (i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - atan_step(i);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + atan_step(i);
      end
    end
    return x;
  endfunction

  // command for one tick item, updates stopped flag and kept error
  function automatic motion_cmd_t next_command(input logic signed [15:0] px,
                                               input logic signed [15:0] py,
                                               input logic signed [15:0] hd);
    motion_cmd_t c;
    longint dx, dy, h, aerr, lerr, mag;
    logic in_bounds;
    c = '0;
    c.idle_waiting = stopped;
    if (!stopped) begin
      in_bounds = goal_x >= wall_l && goal_x <= wall_r && goal_y >= wall_b && goal_y <= wall_t;
      if (in_bounds) begin
        dx = (longint'(goal_x) - longint'(px)) * 256;
        dy = (longint'(goal_y) - longint'(py)) * 256;
        h = longint'(hd) * 8;
        aerr = bearing_q16(dx, dy) - h;
        lerr = (project_x(dx, dy, -h) * INV_GAIN_Q16) >>> 24;
        kept_error = clamp16(lerr);
        if (lerr > 0) c.linear_speed = clamp16((longint'(lin_gain) * lerr) >>> 15);
        c.angular_speed = clamp16((longint'(ang_gain) * aerr) >>> 20);
        c.cmd_valid = 1'b1;
      end else begin
        c.out_of_range = 1'b1;
      end
    end
    // the stop test runs on every tick, with or without a command
    mag = longint'(kept_error);
    if (mag < 0) mag = -mag;
    c.goal_reached = mag < longint'(stop_tol);
    if (c.goal_reached) stopped = 1'b1;
    return c;
  endfunction

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      mismatches_o++;
      if (mismatches_o <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // watch both channels and the register port at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_gain = 16'd2048;
      ang_gain = 16'd16384;
      stop_tol = 15'd20;
      wall_l = 16'sd0;
      wall_r = 16'sd22528;
      wall_b = 16'sd0;
      wall_t = 16'sd22528;
      goal_x = '0;
      goal_y = '0;
      stopped = 1'b1;
      kept_error = '0;
      expected_cmds.delete();
      mismatches_o = 0;
      pending_o = 0;
    end else begin
      // result items against the oldest expected command
      if (out_valid_i && !out_stall_i) begin
        if (expected_cmds.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= MAX_REPORTS)
            $display("%0t: unexpected result, expected none, actual cmd %0b lin %0d ang %0d",
                     $time, cmd_valid_i, linear_speed_i, angular_speed_i);
        end else begin
          want_cmd = expected_cmds.pop_front();
          check_field("cmd_valid", want_cmd.cmd_valid, cmd_valid_i);
          check_field("linear_speed", want_cmd.linear_speed, linear_speed_i);
          check_field("angular_speed", want_cmd.angular_speed, angular_speed_i);
          check_field("out_of_range", want_cmd.out_of_range, out_of_range_i);
          check_field("idle_waiting", want_cmd.idle_waiting, idle_waiting_i);
          check_field("goal_reached", want_cmd.goal_reached, goal_reached_i);
        end
      end
      // input items
      if (in_valid_i && !in_stall_i) begin
        if (opcode_i == OP_GOAL) begin
          goal_x = pos_x_i;
          goal_y = pos_y_i;
          stopped = 1'b0;
        end else begin
          expected_cmds.push_back(next_command(pos_x_i, pos_y_i, heading_i));
        end
      end
      // register writes, unmapped indexes ignored
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LINEAR_GAIN:  lin_gain = cfg_data_i;
          CFG_ANGULAR_GAIN: ang_gain = cfg_data_i;
          CFG_STOP_TOL:     stop_tol = cfg_data_i[14:0];
          CFG_WALL_LEFT:    wall_l = cfg_data_i;
          CFG_WALL_RIGHT:   wall_r = cfg_data_i;
          CFG_WALL_BOTTOM:  wall_b = cfg_data_i;
          CFG_WALL_TOP:     wall_t = cfg_data_i;
          default: ;
        endcase
      end
      pending_o = expected_cmds.size();
    end
  end

endmodule

>>> verif/go_to_goal_p_controller_core_test.sv
// stimulus, watchdog and verdict for the go-to-goal controller testbench
module go_to_goal_p_controller_core_test;
  import ggpc_pkg::*;

  localparam int unsigned ITERS = 16;
  localparam int DRAIN_CYCLES = 2 * ITERS + 30;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS = 205;
  localparam logic [2:0] CFG_UNMAPPED = 3'd7;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               opcode_i = OP_GOAL;
  logic signed [15:0] pos_x_i = '0;
  logic signed [15:0] pos_y_i = '0;
  logic signed [15:0] heading_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               cmd_valid_o;
  logic signed [15:0] linear_speed_o;
  logic signed [15:0] angular_speed_o;
  logic               out_of_range_o;
  logic               idle_waiting_o;
  logic               goal_reached_o;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = '0;
  logic [15:0]        cfg_data_i = '0;

  int                 mismatches;
  int                 pending;
  int                 items_sent = 0;
  int unsigned        idle_cycles = 0;
  logic               quiet = 1'b0;

  // wall settings as the stimulus sees them, for aiming goals
  int wl = 0, wr = 22528, wb = 0, wt = 22528;

  always #6 clk_i = ~clk_i;

  go_to_goal_p_controller_core #(
    .CORDIC_ITERATIONS(ITERS)
  ) dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .opcode_i, .pos_x_i, .pos_y_i, .heading_i,
    .out_valid_o, .out_stall_i, .cmd_valid_o, .linear_speed_o, .angular_speed_o,
    .out_of_range_o, .idle_waiting_o, .goal_reached_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  ggpc_command_checker #(
    .ITERS(ITERS)
  ) u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .opcode_i, .pos_x_i, .pos_y_i, .heading_i,
    .out_valid_i(out_valid_o), .out_stall_i, .cmd_valid_i(cmd_valid_o),
    .linear_speed_i(linear_speed_o), .angular_speed_i(angular_speed_o),
    .out_of_range_i(out_of_range_o), .idle_waiting_i(idle_waiting_o),
    .goal_reached_i(goal_reached_o),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .mismatches_o(mismatches), .pending_o(pending)
  );

  // random back-pressure on the result side
  always @(negedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(0, 99) < 25);
  end

  // end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic signed [15:0] rand16();
    return 16'($urandom());
  endfunction

  function automatic int rand_between(input int lo, input int hi);
    if (lo > hi) return int'(rand16());
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // one item, with random idle cycles before it; returns at a falling edge
  task automatic send_item(input logic op, input logic signed [15:0] x,
                           input logic signed [15:0] y, input logic signed [15:0] h);
    while (!quiet && $urandom_range(0, 99) < 25) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    pos_x_i <= x;
    pos_y_i <= y;
    heading_i <= h;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  // let every expected command arrive and the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
  endtask

  task automatic apply_settings(input logic [15:0] lin, input logic [15:0] ang,
                                input logic [15:0] tol, input int l, input int r,
                                input int b, input int t);
    write_reg(CFG_LINEAR_GAIN, lin);
    write_reg(CFG_ANGULAR_GAIN, ang);
    write_reg(CFG_STOP_TOL, tol);
    write_reg(CFG_WALL_LEFT, 16'(l));
    write_reg(CFG_WALL_RIGHT, 16'(r));
    write_reg(CFG_WALL_BOTTOM, 16'(b));
    write_reg(CFG_WALL_TOP, 16'(t));
    cfg_we_i <= 1'b0;
    wl = int'($signed(16'(l)));
    wr = int'($signed(16'(r)));
    wb = int'($signed(16'(b)));
    wt = int'($signed(16'(t)));
  endtask

  // goal inside the walls, then ticks closing in on it
  task automatic approach();
    int gx, gy, steps, span, s, k, extra;
    gx = rand_between(wl, wr);
    gy = rand_between(wb, wt);
    send_item(OP_GOAL, 16'(gx), 16'(gy), rand16());
    steps = $urandom_range(1, 6);
    case ($urandom_range(0, 2))
      0:       span = 12000;
      1:       span = 1500;
      default: span = 100;
    endcase
    for (k = 0; k < steps; k++) begin
      s = (k == steps - 1) ? $urandom_range(0, 12) : (span >> k);
      send_item(OP_TICK,
                16'(gx - (int'($urandom_range(0, 2 * s)) - s)),
                16'(gy - (int'($urandom_range(0, 2 * s)) - s)),
                rand16());
    end
    // a few more ticks, mostly seen while stopped
    extra = $urandom_range(0, 2);
    for (k = 0; k < extra; k++) send_item(OP_TICK, 16'(gx), 16'(gy), rand16());
  endtask

  task automatic run_random(input int n);
    int target, pick, k, ticks;
    target = items_sent + n;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        approach();
      end else if (pick < 85) begin
        send_item(OP_TICK, rand16(), rand16(), rand16());
      end else begin
        // goal anywhere, often outside the walls
        send_item(OP_GOAL, rand16(), rand16(), rand16());
        ticks = $urandom_range(1, 3);
        for (k = 0; k < ticks; k++) send_item(OP_TICK, rand16(), rand16(), rand16());
      end
    end
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed items under the reset settings
    send_item(OP_TICK, 16'sd0, 16'sd0, 16'sd0);              // stopped after reset
    send_item(OP_GOAL, 16'sd0, 16'sd0, 16'sh7fff);           // heading ignored
    send_item(OP_TICK, 16'sd0, 16'sd0, 16'sd0);              // zero vector
    send_item(OP_TICK, 16'sd100, 16'sd100, 16'sd0);          // waiting for a goal
    send_item(OP_GOAL, 16'sd22528, 16'sd22528, 16'sd0);
    send_item(OP_TICK, -16'sd32768, -16'sd32768, 16'sd0);    // kept error saturates
    send_item(OP_TICK, -16'sd32768, -16'sd32768, 16'sh7fff);
    send_item(OP_TICK, -16'sd32768, -16'sd32768, -16'sd32768);
    send_item(OP_TICK, 16'sh7fff, 16'sh7fff, 16'sd0);         // dx and dy negative
    send_item(OP_TICK, 16'sh7fff, 16'sd0, 16'sd16384);        // dx negative, dy positive
    send_item(OP_TICK, 16'sd0, 16'sh7fff, -16'sd16384);       // dx positive, dy negative
    send_item(OP_TICK, 16'sd22528, 16'sd22528, 16'sd0);       // on the goal
    send_item(OP_GOAL, -16'sd1, 16'sd100, 16'sd0);            // left of the walls
    send_item(OP_TICK, 16'sd0, 16'sd0, 16'sd0);
    send_item(OP_GOAL, 16'sd22529, 16'sd100, 16'sd0);         // right of the walls
    send_item(OP_TICK, 16'sd0, 16'sd0, 16'sd0);
    send_item(OP_GOAL, 16'sd100, -16'sd1, 16'sd0);            // below the walls
    send_item(OP_TICK, 16'sd0, 16'sd0, 16'sd0);
    send_item(OP_GOAL, 16'sd100, 16'sd22529, 16'sd0);         // above the walls
    send_item(OP_TICK, 16'sd0, 16'sd0, 16'sd0);
    send_item(OP_GOAL, 16'sd11264, 16'sd11264, 16'sd0);
    send_item(OP_TICK, 16'sd0, 16'sd11264, -16'sd25736);      // facing away, no forward speed
    send_item(OP_TICK, 16'sd11264, 16'sd11254, 16'sd0);       // close enough to stop
    send_item(OP_GOAL, 16'sh7fff, -16'sd32768, 16'sd0);
    send_item(OP_TICK, -16'sd32768, 16'sh7fff, 16'sd0);

    // unmapped register index leaves the settings alone
    drain();
    write_reg(CFG_UNMAPPED, 16'hffff);
    cfg_we_i <= 1'b0;
    run_random(PHASE_ITEMS);

    // moderate gains, walls around the origin
    drain();
    apply_settings(16'd4096, 16'd8192, 16'd200, -8192, 8192, -8192, 8192);
    run_random(PHASE_ITEMS);

    // largest values everywhere, no idling on either side
    drain();
    quiet = 1'b1;
    apply_settings(16'hffff, 16'hffff, 16'hffff, -32768, 32767, -32768, 32767);
    run_random(PHASE_ITEMS);
    drain();
    quiet = 1'b0;

    // zero gains and tolerance, walls crossed so no goal is inside
    apply_settings(16'h0000, 16'h0000, 16'h0000, 32767, -32768, 32767, -32768);
    run_random(PHASE_ITEMS);

    // random settings with ordered walls
    drain();
    begin
      int a, b2, c, d;
      a = int'(rand16());
      b2 = int'(rand16());
      c = int'(rand16());
      d = int'(rand16());
      apply_settings(16'($urandom()), 16'($urandom()), 16'($urandom_range(0, 500)),
                     (a < b2) ? a : b2, (a < b2) ? b2 : a,
                     (c < d) ? c : d, (c < d) ? d : c);
    end
    run_random(PHASE_ITEMS);

    // strongest forward gain, weakest turn gain, tightest tolerance
    drain();
    apply_settings(16'hffff, 16'h0001, 16'h0001, -32768, 32767, -32768, 32767);
    run_random(PHASE_ITEMS);

    drain();
    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
